// ===== sv/dce_pkg.sv =====
// Package for the drive command encoder: widths, register indexes, state codes
// and the structs passed between the front end, the queue, the radius unit and
// the byte serializer. No dependencies.
package dce_pkg;

  localparam int RATE_FRAC_BITS = 12;

  localparam int WORD_W        = 16;
  localparam int MAG_W         = 15;
  localparam int NUM_W         = MAG_W + RATE_FRAC_BITS;
  localparam int QUOT_W        = 16;
  localparam int BITS_PER_STEP = 4;
  localparam int DIV_STEPS     = QUOT_W / BITS_PER_STEP;
  localparam int STEP_W        = $clog2(DIV_STEPS);
  localparam int PROD_W        = 26;
  localparam int CMD_BYTES     = 5;
  localparam int POS_W         = 3;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 15;

  localparam logic [RATE_FRAC_BITS-1:0] FRAC_HALF =
    RATE_FRAC_BITS'(1) << (RATE_FRAC_BITS - 1);

  localparam logic [WORD_W-1:0] RADIUS_STRAIGHT = 16'h8000;
  localparam logic [WORD_W-1:0] RADIUS_SPIN_CCW = 16'h0001;
  localparam logic [WORD_W-1:0] RADIUS_SPIN_CW  = 16'hFFFF;
  localparam logic [QUOT_W:0]   CAP_NEG         = 17'd32768;
  localparam logic [QUOT_W:0]   CAP_POS         = 17'd32767;

  localparam logic [14:0] SPEED_LIMIT_RST  = 15'd500;
  localparam logic [14:0] RADIUS_LIMIT_RST = 15'd2000;
  localparam logic [9:0]  AXLE_LENGTH_RST  = 10'd258;
  localparam logic [7:0]  OPCODE_RST       = 8'd137;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPEED_LIMIT  = 2'd0,
    CFG_RADIUS_LIMIT = 2'd1,
    CFG_AXLE_LENGTH  = 2'd2,
    CFG_OPCODE       = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_BUSY,
    DIV_DONE
  } div_state_t;

  typedef enum logic [POS_W-1:0] {
    POS_OPCODE   = 3'd0,
    POS_SPEED_HI = 3'd1,
    POS_SPEED_LO = 3'd2,
    POS_RAD_HI   = 3'd3,
    POS_RAD_LO   = 3'd4
  } byte_pos_t;

  typedef struct packed {
    logic [14:0] speed_limit_mm_s;
    logic [14:0] radius_limit_mm;
    logic [9:0]  axle_length_mm;
    logic [7:0]  drive_opcode;
  } cfg_regs_t;

  typedef struct packed {
    logic              need_div;
    logic              neg;
    logic [WORD_W-1:0] speed;
    logic [WORD_W-1:0] radius;
    logic [WORD_W-1:0] rate_mag;
  } entry_t;

  typedef struct packed {
    logic [WORD_W-1:0] speed;
    logic [WORD_W-1:0] radius;
  } cmd_t;

endpackage

// ===== sv/dce_ifs.sv =====
// Channel interfaces of the drive command encoder: input items, result bytes
// and configuration writes, each with valid/ready. No dependencies.
interface dce_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] speed_mm_s;
  logic signed [15:0] turn_rate;
  modport source (output valid, speed_mm_s, turn_rate, input ready);
  modport sink (input valid, speed_mm_s, turn_rate, output ready);
endinterface

interface dce_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] command_byte;
  logic       last_byte;
  modport source (output valid, command_byte, last_byte, input ready);
  modport sink (input valid, command_byte, last_byte, output ready);
endinterface

interface dce_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [14:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/dce_front.sv =====
// Front end: accepts input items, clamps the speed, classifies the turn and
// computes the turn-in-place speed. Depends on dce_pkg and dce_in_if.
module dce_front
  import dce_pkg::*;
(
  dce_in_if.sink     in_ch,
  input  cfg_regs_t  cfg,
  input  logic       q_full,
  output logic       q_push,
  output entry_t     q_entry
);

  logic signed [WORD_W-1:0] spd_in;
  logic signed [WORD_W-1:0] rate;
  logic signed [WORD_W-1:0] lim_s;
  logic signed [WORD_W-1:0] neg_lim;
  logic signed [WORD_W-1:0] clamped;
  logic [WORD_W-1:0]        rate_mag;
  logic [PROD_W-1:0]        prod;
  logic [PROD_W-1:0]        prod_q;
  logic [RATE_FRAC_BITS-1:0] prod_r;
  logic                     round_up;
  logic [WORD_W-1:0]        spin_speed;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    spd_in  = in_ch.speed_mm_s;
    rate    = in_ch.turn_rate;
    lim_s   = signed'({1'b0, cfg.speed_limit_mm_s});
    neg_lim = -lim_s;
    if (spd_in > lim_s) begin
      clamped = lim_s;
    end else if (spd_in < neg_lim) begin
      clamped = neg_lim;
    end else begin
      clamped = spd_in;
    end

    rate_mag   = rate[WORD_W-1] ? WORD_W'(-rate) : WORD_W'(rate);
    prod       = PROD_W'(cfg.axle_length_mm) * PROD_W'(rate_mag);
    prod_q     = prod >> RATE_FRAC_BITS;
    prod_r     = prod[RATE_FRAC_BITS-1:0];
    round_up   = (prod_r > FRAC_HALF) || ((prod_r == FRAC_HALF) && prod_q[0]);
    spin_speed = WORD_W'(prod_q) + WORD_W'(round_up);

    q_entry.rate_mag = rate_mag;
    q_entry.neg      = clamped[WORD_W-1] ^ rate[WORD_W-1];
    if (rate == '0) begin
      q_entry.need_div = 1'b0;
      q_entry.speed    = WORD_W'(clamped);
      q_entry.radius   = RADIUS_STRAIGHT;
    end else if (spd_in == '0) begin
      q_entry.need_div = 1'b0;
      q_entry.speed    = spin_speed;
      q_entry.radius   = rate[WORD_W-1] ? RADIUS_SPIN_CW : RADIUS_SPIN_CCW;
    end else begin
      q_entry.need_div = 1'b1;
      q_entry.speed    = WORD_W'(clamped);
      q_entry.radius   = '0;
    end
  end

endmodule

// ===== sv/dce_queue.sv =====
// Two-entry queue between the front end and the radius unit.
// Depends on dce_pkg.
module dce_queue
  import dce_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output entry_t pop_entry,
  output logic   empty
);

  entry_t            entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign pop_entry = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== sv/dce_radius_unit.sv =====
// Radius unit: divides the scaled speed by the turn rate four quotient bits
// per cycle, then rounds, saturates, halves and clamps. Depends on dce_pkg.
module dce_radius_unit
  import dce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [14:0] radius_limit_mm,
  input  logic        q_empty,
  input  entry_t      q_entry,
  output logic        q_pop,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);

  div_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r;
  logic              need_div_r;
  logic              neg_r;
  logic              ovf_r;
  logic [WORD_W-1:0] speed_r;
  logic [WORD_W-1:0] radius_r;
  logic [WORD_W-1:0] den_r;
  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [QUOT_W-1:0] quo_r, quo_nxt;

  logic [MAG_W-1:0]  spd_mag;
  logic [NUM_W-1:0]  num;
  logic [WORD_W-1:0] num_hi;
  logic [WORD_W:0]   trial;

  logic [WORD_W:0]   rem2;
  logic              rnd;
  logic [QUOT_W:0]   q_round;
  logic [QUOT_W:0]   cap;
  logic [QUOT_W:0]   mag_sat;
  logic [WORD_W-1:0] half_mag;
  logic [WORD_W-1:0] lim_mag;
  logic [WORD_W-1:0] div_radius;

  always_comb begin
    spd_mag = q_entry.speed[WORD_W-1] ? MAG_W'(-q_entry.speed) : MAG_W'(q_entry.speed);
    num     = {spd_mag, {RATE_FRAC_BITS{1'b0}}};
    num_hi  = WORD_W'(num >> QUOT_W);
  end

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    trial   = '0;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      trial   = {rem_nxt, quo_nxt[QUOT_W-1]};
      quo_nxt = {quo_nxt[QUOT_W-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        trial      = trial - {1'b0, den_r};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = trial[WORD_W-1:0];
    end
  end

  always_comb begin
    rem2       = {rem_r, 1'b0};
    rnd        = (rem2 > {1'b0, den_r}) || ((rem2 == {1'b0, den_r}) && quo_r[0]);
    q_round    = {1'b0, quo_r} + (QUOT_W + 1)'(rnd);
    cap        = neg_r ? CAP_NEG : CAP_POS;
    mag_sat    = (ovf_r || (q_round > cap)) ? cap : q_round;
    half_mag   = mag_sat[QUOT_W:1];
    lim_mag    = (half_mag > {1'b0, radius_limit_mm}) ? {1'b0, radius_limit_mm} : half_mag;
    div_radius = neg_r ? WORD_W'(-lim_mag) : lim_mag;
  end

  assign cmd_valid  = (state_r == DIV_DONE);
  assign cmd.speed  = speed_r;
  assign cmd.radius = need_div_r ? div_radius : radius_r;

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    unique case (state_r)
      DIV_IDLE: begin
        q_pop = !q_empty;
      end
      DIV_BUSY: begin
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = DIV_DONE;
        end
      end
      DIV_DONE: begin
        if (cmd_ready) begin
          q_pop     = !q_empty;
          state_nxt = DIV_IDLE;
        end
      end
      default: begin
        state_nxt = DIV_IDLE;
      end
    endcase
    if (q_pop) begin
      state_nxt = q_entry.need_div ? DIV_BUSY : DIV_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DIV_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        step_r <= '0;
      end else if (state_r == DIV_BUSY) begin
        step_r <= step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      need_div_r <= q_entry.need_div;
      neg_r      <= q_entry.neg;
      speed_r    <= q_entry.speed;
      radius_r   <= q_entry.radius;
      den_r      <= q_entry.rate_mag;
      ovf_r      <= (num_hi >= q_entry.rate_mag);
      rem_r      <= num_hi;
      quo_r      <= num[QUOT_W-1:0];
    end else if (state_r == DIV_BUSY) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

endmodule

// ===== sv/dce_serializer.sv =====
// Byte serializer: holds one finished command and sends it as five bytes.
// Depends on dce_pkg and dce_out_if.
module dce_serializer
  import dce_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] drive_opcode,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_t       cmd,
  dce_out_if.source  out_ch
);

  logic      busy_r;
  byte_pos_t pos_r;
  cmd_t      cmd_r;
  logic      xfer;
  logic      last;

  assign last      = (pos_r == POS_RAD_LO);
  assign xfer      = out_ch.valid && out_ch.ready;
  assign cmd_ready = !busy_r || (xfer && last);

  assign out_ch.valid     = busy_r;
  assign out_ch.last_byte = last;

  always_comb begin
    unique case (pos_r)
      POS_OPCODE:   out_ch.command_byte = drive_opcode;
      POS_SPEED_HI: out_ch.command_byte = cmd_r.speed[15:8];
      POS_SPEED_LO: out_ch.command_byte = cmd_r.speed[7:0];
      POS_RAD_HI:   out_ch.command_byte = cmd_r.radius[15:8];
      POS_RAD_LO:   out_ch.command_byte = cmd_r.radius[7:0];
      default:      out_ch.command_byte = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= POS_OPCODE;
    end else if (cmd_valid && cmd_ready) begin
      busy_r <= 1'b1;
      pos_r  <= POS_OPCODE;
    end else if (xfer) begin
      if (last) begin
        busy_r <= 1'b0;
      end else begin
        pos_r <= byte_pos_t'(pos_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      cmd_r <= cmd;
    end
  end

endmodule

// ===== sv/drive_command_encoder_unit.sv =====
// Top level of the drive command encoder: configuration registers, front end,
// queue, radius unit and byte serializer. Depends on dce_pkg and dce_ifs.
//
// Usage: in_ch carries one speed (mm/s) and one turn rate (Q4.12 rad/s) per
// transfer. Each item yields one five-byte command on out_ch: opcode, speed
// high, speed low, radius high, radius low, with last_byte set on the fifth.
// cfg_ch writes the speed limit, radius limit, axle length and opcode by
// index; it is always ready, and the user must write it only while the block
// is idle: the block itself does not enforce this. An item that needs a
// division passes through the queue, the divider's busy and done states and
// the serializer; straight and turn-in-place items skip the division. The
// divider produces four quotient bits per cycle and works on one item at a
// time; the serializer accepts the next command only as it sends the last
// byte of the current one. A two-entry queue sits between the front end and
// the divider; in_ch.ready falls only when it is full. When out_ch stalls,
// the current byte holds and work stops behind it once the queue fills.
// Reset loads the default register values and empties all stages.
module drive_command_encoder_unit
  import dce_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  dce_in_if.sink     in_ch,
  dce_out_if.source  out_ch,
  dce_cfg_if.sink    cfg_ch
);

  cfg_regs_t cfg_r;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;
  entry_t    push_entry;
  entry_t    pop_entry;
  logic      cmd_valid;
  logic      cmd_ready;
  cmd_t      cmd;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_limit_mm_s <= SPEED_LIMIT_RST;
      cfg_r.radius_limit_mm  <= RADIUS_LIMIT_RST;
      cfg_r.axle_length_mm   <= AXLE_LENGTH_RST;
      cfg_r.drive_opcode     <= OPCODE_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_index_t'(cfg_ch.index))
        CFG_SPEED_LIMIT:  cfg_r.speed_limit_mm_s <= cfg_ch.data;
        CFG_RADIUS_LIMIT: cfg_r.radius_limit_mm  <= cfg_ch.data;
        CFG_AXLE_LENGTH:  cfg_r.axle_length_mm   <= cfg_ch.data[9:0];
        CFG_OPCODE:       cfg_r.drive_opcode     <= cfg_ch.data[7:0];
        default: begin
        end
      endcase
    end
  end

  dce_front u_front (
    .in_ch   (in_ch),
    .cfg     (cfg_r),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (push_entry)
  );

  dce_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .empty      (q_empty)
  );

  dce_radius_unit u_radius (
    .clk             (clk),
    .rst_n           (rst_n),
    .radius_limit_mm (cfg_r.radius_limit_mm),
    .q_empty         (q_empty),
    .q_entry         (pop_entry),
    .q_pop           (q_pop),
    .cmd_valid       (cmd_valid),
    .cmd_ready       (cmd_ready),
    .cmd             (cmd)
  );

  dce_serializer u_ser (
    .clk          (clk),
    .rst_n        (rst_n),
    .drive_opcode (cfg_r.drive_opcode),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .out_ch       (out_ch)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  a_bytes_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last_byte) |=> out_ch.valid)
    else $error("gap inside a command");

  a_cmd_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_valid && !cmd_ready) |=> (cmd_valid && $stable(cmd)))
    else $error("finished command changed before the serializer took it");

endmodule
